### src/fct_pkg.sv
package fct_pkg;

  localparam int TABLE_ENTRIES_DEF = 1024;
  localparam int BLK_W = 10;
  localparam int ENT_W = 11;
  localparam int VAL_W = 11;

  localparam logic [ENT_W-1:0] END_MARK = '1;

  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_ADD,
    OP_LOOKUP,
    OP_REMOVE
  } op_t;

  typedef enum logic [3:0] {
    ST_SWEEP_RST,
    ST_IDLE,
    ST_DECODE,
    ST_SWEEP_CLR,
    ST_ADD_T,
    ST_ADD_C,
    ST_ADD_W,
    ST_LK_CHK,
    ST_LK_EV,
    ST_RM1_RD,
    ST_RM1_EV,
    ST_RM2_RD,
    ST_RM2_EV,
    ST_POST
  } state_t;

  typedef enum logic [1:0] {RA_TGT, RA_CHAIN, RA_CUR} rd_sel_t;
  typedef enum logic [1:0] {WA_TGT, WA_CHAIN, WA_CUR, WA_SWEEP} wa_sel_t;
  typedef enum logic [1:0] {WD_ZERO, WD_END, WD_TGT} wd_sel_t;
  typedef enum logic [1:0] {CUR_HOLD, CUR_CHAIN, CUR_RD, CUR_TGT} cur_sel_t;
  typedef enum logic [1:0] {VAL_ZERO, VAL_CUR, VAL_CNT1} val_sel_t;

  typedef struct packed {
    logic     in_ready;
    logic     load_in;
    rd_sel_t  rd_sel;
    logic     wr_en;
    wa_sel_t  wa_sel;
    wd_sel_t  wd_sel;
    cur_sel_t cur_sel;
    logic     steps_clr;
    logic     steps_inc;
    logic     count_clr;
    logic     count_inc;
    logic     links_dec;
    logic     sweep_clr;
    logic     sweep_inc;
    logic     res_load;
    logic     res_err;
    val_sel_t val_sel;
    logic     post;
  } dp_ctl_t;

  typedef struct packed {
    logic in_valid;
    logic out_busy;
    op_t  op;
    logic chain_end;
    logic chain_rng;
    logic tgt_rng;
    logic rd_zero;
    logic rd_end;
    logic rd_rng;
    logic rd_eq_tgt;
    logic links_zero;
    logic steps_max;
    logic sweep_last;
  } dp_sts_t;

endpackage

### src/fct_cmd_if.sv
interface fct_cmd_if
  import fct_pkg::*;
  ();
  logic                    valid;
  logic                    ready;
  logic [1:0]              opcode;
  logic signed [ENT_W-1:0] chain_block;
  logic [BLK_W-1:0]        target_block;
  logic [BLK_W-1:0]        logical_index;

  modport source (output valid, opcode, chain_block, target_block, logical_index,
                  input ready);
  modport sink (input valid, opcode, chain_block, target_block, logical_index,
                output ready);
endinterface

### src/fct_rsp_if.sv
interface fct_rsp_if
  import fct_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic             status;
  logic [VAL_W-1:0] value;

  modport source (output valid, status, value, input ready);
  modport sink (input valid, status, value, output ready);
endinterface

### src/fct_dp.sv
module fct_dp
  import fct_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic      clk,
  input  logic      rst,
  fct_cmd_if.sink   cmd,
  fct_rsp_if.source rsp,
  input  dp_ctl_t   ctl,
  output dp_sts_t   sts
);

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int SW = $clog2(TABLE_ENTRIES + 1);

  logic [ENT_W-1:0] mem [TABLE_ENTRIES];

  op_t              op;
  logic [ENT_W-1:0] chain;
  logic [BLK_W-1:0] tgt;
  logic [BLK_W-1:0] links;
  logic [BLK_W-1:0] cur;
  logic [ENT_W-1:0] rdata;
  logic [SW-1:0]    steps;
  logic [VAL_W-1:0] count;
  logic [AW-1:0]    sweep;
  logic             res_status;
  logic [VAL_W-1:0] res_value;
  logic             out_valid;
  logic             out_status;
  logic [VAL_W-1:0] out_value;

  logic [AW-1:0]    ra;
  logic [AW-1:0]    wa;
  logic [ENT_W-1:0] wd;
  logic [VAL_W-1:0] val_next;

  function automatic logic blk_rng(logic [BLK_W-1:0] b);
    return {{(32-BLK_W){1'b0}}, b} < 32'(TABLE_ENTRIES);
  endfunction

  always_comb begin
    unique case (ctl.rd_sel)
      RA_TGT:   ra = AW'(tgt);
      RA_CHAIN: ra = AW'(chain[BLK_W-1:0]);
      RA_CUR:   ra = AW'(cur);
      default:  ra = AW'(cur);
    endcase
    unique case (ctl.wa_sel)
      WA_TGT:   wa = AW'(tgt);
      WA_CHAIN: wa = AW'(chain[BLK_W-1:0]);
      WA_CUR:   wa = AW'(cur);
      WA_SWEEP: wa = sweep;
      default:  wa = sweep;
    endcase
    unique case (ctl.wd_sel)
      WD_ZERO: wd = '0;
      WD_END:  wd = END_MARK;
      WD_TGT:  wd = {1'b0, tgt};
      default: wd = '0;
    endcase
    unique case (ctl.val_sel)
      VAL_ZERO: val_next = '0;
      VAL_CUR:  val_next = {1'b0, cur};
      VAL_CNT1: val_next = count + VAL_W'(1);
      default:  val_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wa] <= wd;
    end
    rdata <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (ctl.load_in) begin
      op    <= op_t'(cmd.opcode);
      chain <= cmd.chain_block;
      tgt   <= cmd.target_block;
      links <= cmd.logical_index;
    end else if (ctl.links_dec) begin
      links <= links - BLK_W'(1);
    end
    unique case (ctl.cur_sel)
      CUR_HOLD:  cur <= cur;
      CUR_CHAIN: cur <= chain[BLK_W-1:0];
      CUR_RD:    cur <= rdata[BLK_W-1:0];
      CUR_TGT:   cur <= tgt;
      default:   cur <= cur;
    endcase
    if (ctl.steps_clr) begin
      steps <= '0;
    end else if (ctl.steps_inc) begin
      steps <= steps + SW'(1);
    end
    if (ctl.count_clr) begin
      count <= '0;
    end else if (ctl.count_inc) begin
      count <= count + VAL_W'(1);
    end
    if (ctl.res_load) begin
      res_status <= ctl.res_err;
      res_value  <= ctl.res_err ? '0 : val_next;
    end
    if (ctl.post) begin
      out_status <= res_status;
      out_value  <= res_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (ctl.sweep_clr) begin
        sweep <= '0;
      end else if (ctl.sweep_inc) begin
        sweep <= sweep + AW'(1);
      end
      if (ctl.post) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign cmd.ready  = ctl.in_ready;
  assign rsp.valid  = out_valid;
  assign rsp.status = out_status;
  assign rsp.value  = out_value;

  assign sts.in_valid   = cmd.valid;
  assign sts.out_busy   = out_valid && !rsp.ready;
  assign sts.op         = op;
  assign sts.chain_end  = (chain == END_MARK);
  assign sts.chain_rng  = !chain[ENT_W-1] && blk_rng(chain[BLK_W-1:0]);
  assign sts.tgt_rng    = blk_rng(tgt);
  assign sts.rd_zero    = (rdata == '0);
  assign sts.rd_end     = (rdata == END_MARK);
  assign sts.rd_rng     = !rdata[ENT_W-1] && blk_rng(rdata[BLK_W-1:0]);
  assign sts.rd_eq_tgt  = (rdata == {1'b0, tgt});
  assign sts.links_zero = (links == '0);
  assign sts.steps_max  = (steps == SW'(TABLE_ENTRIES));
  assign sts.sweep_last = (sweep == AW'(TABLE_ENTRIES - 1));

endmodule

### src/fct_ctrl.sv
module fct_ctrl
  import fct_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  dp_sts_t sts,
  output dp_ctl_t ctl
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_SWEEP_RST;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    ctl        = '0;
    state_next = state;
    unique case (state)
      ST_SWEEP_RST: begin
        ctl.wr_en     = 1'b1;
        ctl.wa_sel    = WA_SWEEP;
        ctl.wd_sel    = WD_ZERO;
        ctl.sweep_inc = 1'b1;
        if (sts.sweep_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        ctl.in_ready = 1'b1;
        ctl.load_in  = sts.in_valid;
        if (sts.in_valid) begin
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        ctl.cur_sel   = CUR_CHAIN;
        ctl.steps_clr = 1'b1;
        ctl.count_clr = 1'b1;
        ctl.sweep_clr = 1'b1;
        ctl.rd_sel    = RA_TGT;
        ctl.val_sel   = VAL_ZERO;
        unique case (sts.op)
          OP_CLEAR: state_next = ST_SWEEP_CLR;
          OP_ADD: begin
            if (!sts.tgt_rng) begin
              ctl.res_load = 1'b1;
              ctl.res_err  = 1'b1;
              state_next   = ST_POST;
            end else begin
              state_next = ST_ADD_T;
            end
          end
          OP_LOOKUP: begin
            if (!sts.chain_rng) begin
              ctl.res_load = 1'b1;
              ctl.res_err  = 1'b1;
              state_next   = ST_POST;
            end else begin
              state_next = ST_LK_CHK;
            end
          end
          OP_REMOVE: begin
            if (!sts.chain_rng || !sts.tgt_rng) begin
              ctl.res_load = 1'b1;
              ctl.res_err  = 1'b1;
              state_next   = ST_POST;
            end else begin
              state_next = ST_RM1_RD;
            end
          end
          default: state_next = ST_POST;
        endcase
      end
      ST_SWEEP_CLR: begin
        ctl.wr_en     = 1'b1;
        ctl.wa_sel    = WA_SWEEP;
        ctl.wd_sel    = WD_ZERO;
        ctl.sweep_inc = 1'b1;
        if (sts.sweep_last) begin
          ctl.res_load = 1'b1;
          ctl.val_sel  = VAL_ZERO;
          state_next   = ST_POST;
        end
      end
      // rdata holds the target entry
      ST_ADD_T: begin
        ctl.rd_sel = RA_CHAIN;
        if (!sts.rd_zero) begin
          ctl.res_load = 1'b1;
          ctl.res_err  = 1'b1;
          state_next   = ST_POST;
        end else if (sts.chain_end) begin
          ctl.wr_en    = 1'b1;
          ctl.wa_sel   = WA_TGT;
          ctl.wd_sel   = WD_END;
          ctl.res_load = 1'b1;
          ctl.val_sel  = VAL_ZERO;
          state_next   = ST_POST;
        end else if (!sts.chain_rng) begin
          ctl.res_load = 1'b1;
          ctl.res_err  = 1'b1;
          state_next   = ST_POST;
        end else begin
          state_next = ST_ADD_C;
        end
      end
      // rdata holds the last entry of the chain
      ST_ADD_C: begin
        if (!sts.rd_end) begin
          ctl.res_load = 1'b1;
          ctl.res_err  = 1'b1;
          state_next   = ST_POST;
        end else begin
          ctl.wr_en  = 1'b1;
          ctl.wa_sel = WA_CHAIN;
          ctl.wd_sel = WD_TGT;
          state_next = ST_ADD_W;
        end
      end
      ST_ADD_W: begin
        ctl.wr_en    = 1'b1;
        ctl.wa_sel   = WA_TGT;
        ctl.wd_sel   = WD_END;
        ctl.res_load = 1'b1;
        ctl.val_sel  = VAL_ZERO;
        state_next   = ST_POST;
      end
      ST_LK_CHK: begin
        ctl.rd_sel = RA_CUR;
        if (sts.links_zero) begin
          ctl.res_load = 1'b1;
          ctl.val_sel  = VAL_CUR;
          state_next   = ST_POST;
        end else begin
          state_next = ST_LK_EV;
        end
      end
      ST_LK_EV: begin
        if (sts.rd_zero || sts.rd_end || !sts.rd_rng) begin
          ctl.res_load = 1'b1;
          ctl.res_err  = 1'b1;
          state_next   = ST_POST;
        end else begin
          ctl.cur_sel   = CUR_RD;
          ctl.links_dec = 1'b1;
          state_next    = ST_LK_CHK;
        end
      end
      ST_RM1_RD: begin
        ctl.rd_sel = RA_CUR;
        state_next = ST_RM1_EV;
      end
      // find the block that links to the target block, then cut there
      ST_RM1_EV: begin
        if (sts.rd_eq_tgt) begin
          ctl.wr_en     = 1'b1;
          ctl.wa_sel    = WA_CUR;
          ctl.wd_sel    = WD_END;
          ctl.cur_sel   = CUR_TGT;
          ctl.steps_clr = 1'b1;
          state_next    = ST_RM2_RD;
        end else if (sts.rd_zero || sts.rd_end || !sts.rd_rng || sts.steps_max) begin
          ctl.res_load = 1'b1;
          ctl.res_err  = 1'b1;
          state_next   = ST_POST;
        end else begin
          ctl.cur_sel   = CUR_RD;
          ctl.steps_inc = 1'b1;
          state_next    = ST_RM1_RD;
        end
      end
      ST_RM2_RD: begin
        ctl.rd_sel = RA_CUR;
        state_next = ST_RM2_EV;
      end
      // free the tail; blocks already freed stay freed on error
      ST_RM2_EV: begin
        if (sts.rd_end) begin
          ctl.wr_en    = 1'b1;
          ctl.wa_sel   = WA_CUR;
          ctl.wd_sel   = WD_ZERO;
          ctl.res_load = 1'b1;
          ctl.val_sel  = VAL_CNT1;
          state_next   = ST_POST;
        end else if (sts.rd_zero || !sts.rd_rng || sts.steps_max) begin
          ctl.res_load = 1'b1;
          ctl.res_err  = 1'b1;
          state_next   = ST_POST;
        end else begin
          ctl.wr_en     = 1'b1;
          ctl.wa_sel    = WA_CUR;
          ctl.wd_sel    = WD_ZERO;
          ctl.cur_sel   = CUR_RD;
          ctl.count_inc = 1'b1;
          ctl.steps_inc = 1'b1;
          state_next    = ST_RM2_RD;
        end
      end
      ST_POST: begin
        if (!sts.out_busy) begin
          ctl.post   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

### src/fat_chain_table_engine.sv
// Channel  Dir  Fields
// cmd      in   opcode[1:0], chain_block[10:0] signed, target_block[9:0], logical_index[9:0]
// rsp      out  status, value[10:0]
//
// One request at a time. Lookup walks its links, remove walks to the cut and
// then frees each block of the tail, and clear sweeps every table entry;
// every table link costs a registered read of the table memory.
// After reset the table is swept to zero with cmd.ready low.
// The response register frees the controller: a new request is taken while a
// response waits; a held response only stalls the next one from posting.
module fat_chain_table_engine
  import fct_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic      clk,
  input  logic      rst,
  fct_cmd_if.sink   cmd,
  fct_rsp_if.source rsp
);

  dp_ctl_t ctl;
  dp_sts_t sts;

  fct_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .ctl (ctl)
  );

  fct_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .rsp (rsp),
    .ctl (ctl),
    .sts (sts)
  );

endmodule

### dv/fat_chain_table_engine_tb.sv
`timescale 1ns / 1ps

module fat_chain_table_engine_tb
  import fct_pkg::*;
();

  localparam int TBL_N  = TABLE_ENTRIES_DEF;
  localparam int DIR_N  = 25;
  localparam int RAND_N = 1530;

  typedef struct packed {
    op_t                     op;
    logic signed [ENT_W-1:0] chain;
    logic [BLK_W-1:0]        tgt;
    logic [BLK_W-1:0]        links;
  } fat_cmd_t;

  typedef struct packed {
    logic             status;
    logic [VAL_W-1:0] value;
  } fat_rsp_t;

  typedef struct packed {
    op_t                     op;
    logic signed [ENT_W-1:0] chain;
    logic [BLK_W-1:0]        tgt;
    logic [BLK_W-1:0]        links;
    logic                    typed;
    logic                    status;
    logic [VAL_W-1:0]        value;
  } fat_row_t;

  logic clk;
  logic rst;

  fct_cmd_if cmd_if ();
  fct_rsp_if rsp_if ();

  fat_chain_table_engine dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_if),
    .rsp(rsp_if)
  );

  logic signed [ENT_W-1:0] shadow_fat [TBL_N];
  fat_rsp_t                pending_rsp_q [$];
  int                      mismatch_cnt;
  int                      rsp_seen;
  int                      burst_left;

  // Table starts empty; the walk rows rely on the order below.
  fat_row_t dir_rows [DIR_N] = '{
    '{OP_LOOKUP, 11'sd0,     10'd0,    10'd0,    1'b1, 1'b0, 11'd0},
    '{OP_LOOKUP, 11'sd1023,  10'd0,    10'd0,    1'b1, 1'b0, 11'd1023},
    '{OP_LOOKUP, -11'sd1,    10'd0,    10'd0,    1'b1, 1'b1, 11'd0},
    '{OP_LOOKUP, 11'sd5,     10'd0,    10'd1,    1'b1, 1'b1, 11'd0},
    '{OP_ADD,    -11'sd1,    10'd1023, 10'd1023, 1'b1, 1'b0, 11'd0},
    '{OP_ADD,    -11'sd1,    10'd1023, 10'd0,    1'b1, 1'b1, 11'd0},
    '{OP_ADD,    11'sd1023,  10'd512,  10'd0,    1'b1, 1'b0, 11'd0},
    '{OP_ADD,    11'sd1023,  10'd1,    10'd0,    1'b1, 1'b1, 11'd0},
    '{OP_ADD,    11'sd512,   10'd1,    10'd0,    1'b1, 1'b0, 11'd0},
    '{OP_ADD,    -11'sd2,    10'd3,    10'd0,    1'b1, 1'b1, 11'd0},
    '{OP_ADD,    -11'sd1024, 10'd3,    10'd0,    1'b1, 1'b1, 11'd0},
    '{OP_LOOKUP, 11'sd1023,  10'd0,    10'd2,    1'b1, 1'b0, 11'd1},
    '{OP_LOOKUP, 11'sd1023,  10'd0,    10'd3,    1'b1, 1'b1, 11'd0},
    '{OP_LOOKUP, 11'sd1023,  10'd1023, 10'd1023, 1'b1, 1'b1, 11'd0},
    '{OP_REMOVE, -11'sd1024, 10'd0,    10'd0,    1'b1, 1'b1, 11'd0},
    '{OP_REMOVE, 11'sd1023,  10'd5,    10'd0,    1'b1, 1'b1, 11'd0},
    '{OP_REMOVE, 11'sd1023,  10'd512,  10'd0,    1'b1, 1'b0, 11'd2},
    '{OP_REMOVE, 11'sd1023,  10'd1023, 10'd0,    1'b1, 1'b1, 11'd0},
    '{OP_ADD,    11'sd1023,  10'd7,    10'd0,    1'b1, 1'b0, 11'd0},
    // link to block zero leaves an entry that reads as free
    '{OP_ADD,    11'sd7,     10'd0,    10'd0,    1'b1, 1'b0, 11'd0},
    '{OP_REMOVE, 11'sd1023,  10'd7,    10'd0,    1'b1, 1'b1, 11'd0},
    '{OP_REMOVE, 11'sd7,     10'd0,    10'd0,    1'b0, 1'b0, 11'd0},
    '{OP_CLEAR,  11'sd1023,  10'd1023, 10'd1023, 1'b1, 1'b0, 11'd0},
    '{OP_LOOKUP, 11'sd1023,  10'd0,    10'd1,    1'b1, 1'b1, 11'd0},
    '{OP_ADD,    -11'sd1,    10'd0,    10'd0,    1'b0, 1'b0, 11'd0}
  };

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("fat_chain_table_engine_tb: FAIL");
    $finish;
  end

  function automatic bit blk_ok(int b);
    return b >= 0 && b < TBL_N;
  endfunction

  // Runs one request against the shadow table and returns its response.
  function automatic fat_rsp_t apply_fat_command(fat_cmd_t c);
    fat_rsp_t r;
    int       chain, tgt, cur, nxt, e, steps, freed;
    r     = '0;
    chain = int'(c.chain);
    tgt   = int'(c.tgt);
    case (c.op)
      OP_CLEAR: begin
        foreach (shadow_fat[i]) shadow_fat[i] = '0;
      end
      OP_ADD: begin
        if (shadow_fat[tgt] != 0) begin
          r.status = 1'b1;
        end else if (chain == -1) begin
          shadow_fat[tgt] = END_MARK;
        end else if (!blk_ok(chain) || shadow_fat[chain] != END_MARK) begin
          r.status = 1'b1;
        end else begin
          shadow_fat[chain] = ENT_W'(tgt);
          shadow_fat[tgt]   = END_MARK;
        end
      end
      OP_LOOKUP: begin
        cur = chain;
        if (!blk_ok(chain)) begin
          r.status = 1'b1;
        end else begin
          for (int i = 0; i < int'(c.links) && !r.status; i++) begin
            e = int'(shadow_fat[cur]);
            if (e <= 0 || !blk_ok(e)) r.status = 1'b1;
            else cur = e;
          end
          if (!r.status) r.value = VAL_W'(cur);
        end
      end
      default: begin
        if (!blk_ok(chain)) begin
          r.status = 1'b1;
        end else begin
          cur   = chain;
          steps = 0;
          while (!r.status && int'(shadow_fat[cur]) != tgt) begin
            e = int'(shadow_fat[cur]);
            steps++;
            if (e <= 0 || !blk_ok(e) || steps > TBL_N) r.status = 1'b1;
            else cur = e;
          end
          if (!r.status) begin
            nxt             = int'(shadow_fat[cur]);
            shadow_fat[cur] = END_MARK;
            cur             = nxt;
            steps           = 0;
            freed           = 0;
            while (!r.status && shadow_fat[cur] != END_MARK) begin
              e = int'(shadow_fat[cur]);
              steps++;
              if (e == 0 || !blk_ok(e) || steps > TBL_N) begin
                r.status = 1'b1;
              end else begin
                shadow_fat[cur] = '0;
                freed++;
                cur = e;
              end
            end
            if (!r.status) begin
              shadow_fat[cur] = '0;
              r.value = VAL_W'(freed + 1);
            end
          end
        end
      end
    endcase
    return r;
  endfunction

  function automatic int find_entry(logic signed [ENT_W-1:0] v);
    int start;
    start = $urandom_range(0, TBL_N - 1);
    for (int i = 0; i < TBL_N; i++)
      if (shadow_fat[(start + i) % TBL_N] == v) return (start + i) % TBL_N;
    return -1;
  endfunction

  // A head is a used block no other entry points at; len counts its blocks.
  function automatic int pick_head(output int len);
    bit pointed [TBL_N];
    int heads [$];
    int h, e;
    foreach (shadow_fat[i])
      if (shadow_fat[i] > 0) pointed[int'(shadow_fat[i])] = 1'b1;
    foreach (shadow_fat[i])
      if (shadow_fat[i] != 0 && !pointed[i]) heads.push_back(i);
    len = 0;
    if (heads.size() == 0) return -1;
    h   = heads[$urandom_range(0, heads.size() - 1)];
    len = 1;
    e   = h;
    while (shadow_fat[e] > 0 && len <= TBL_N) begin
      e = int'(shadow_fat[e]);
      len++;
    end
    return h;
  endfunction

  task automatic flag_error(string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) $display("%s", msg);
  endtask

  task automatic send_request(fat_cmd_t c, bit typed, fat_rsp_t typed_rsp);
    fat_rsp_t want;
    cmd_if.valid         <= 1'b1;
    cmd_if.opcode        <= c.op;
    cmd_if.chain_block   <= c.chain;
    cmd_if.target_block  <= c.tgt;
    cmd_if.logical_index <= c.links;
    do @(posedge clk); while (!cmd_if.ready);
    want = apply_fat_command(c);
    pending_rsp_q.push_back(typed ? typed_rsp : want);
  endtask

  task automatic pace_sender();
    int gap;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if ($urandom_range(0, 19) == 0) gap = $urandom_range(20, 80);
      if (gap > 0) begin
        cmd_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic drain_responses();
    cmd_if.valid <= 1'b0;
    while (pending_rsp_q.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    fat_rsp_t want;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (pending_rsp_q.size() == 0) begin
        flag_error($sformatf("unexpected response: status %0d value %0d",
                             rsp_if.status, rsp_if.value));
      end else begin
        want = pending_rsp_q.pop_front();
        if (rsp_if.status !== want.status || rsp_if.value !== want.value)
          flag_error($sformatf("response %0d: expected status %0d value %0d, got %0d %0d",
                               rsp_seen, want.status, want.value,
                               rsp_if.status, rsp_if.value));
      end
      rsp_seen++;
    end
  end

  // Response side back-pressure, plus one long hold-off to fill the block.
  initial begin
    int  mode, span;
    bit  held;
    held = 1'b0;
    rsp_if.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (!held && rsp_seen >= 400) begin
        held = 1'b1;
        for (int n = 0; n < 400; n++) begin
          rsp_if.ready <= 1'b0;
          @(posedge clk);
        end
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(10, 150);
      for (int n = 0; n < span; n++) begin
        case (mode)
          0: rsp_if.ready <= 1'b1;
          1: rsp_if.ready <= 1'($urandom_range(0, 1));
          2: rsp_if.ready <= ($urandom_range(0, 3) == 0);
          default: rsp_if.ready <= (n % 3 != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin
    fat_cmd_t c;
    int       roll, head, len, k, pick, blk, drain_cnt;
    mismatch_cnt = 0;
    rsp_seen     = 0;
    burst_left   = 0;
    foreach (shadow_fat[i]) shadow_fat[i] = '0;
    rst                  <= 1'b1;
    cmd_if.valid         <= 1'b0;
    cmd_if.opcode        <= OP_CLEAR;
    cmd_if.chain_block   <= '0;
    cmd_if.target_block  <= '0;
    cmd_if.logical_index <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      c = '{dir_rows[i].op, dir_rows[i].chain, dir_rows[i].tgt, dir_rows[i].links};
      send_request(c, dir_rows[i].typed, {dir_rows[i].status, dir_rows[i].value});
      pace_sender();
    end
    drain_responses();

    for (int n = 0; n < RAND_N; n++) begin
      if (n == RAND_N / 2) drain_responses();
      c.op    = op_t'($urandom_range(0, 3));
      c.chain = ($urandom_range(0, 3) == 0) ? ENT_W'($urandom)
                                            : ENT_W'($urandom_range(0, TBL_N - 1));
      c.tgt   = BLK_W'($urandom);
      c.links = BLK_W'($urandom);
      roll    = $urandom_range(0, 99);
      if (roll < 2) begin
        c.op = OP_CLEAR;
      end else if (roll < 42) begin
        c.op = OP_ADD;
        blk  = find_entry('0);
        if (blk >= 0 && $urandom_range(0, 9) != 0) c.tgt = BLK_W'(blk);
        k = $urandom_range(0, 9);
        if (k < 3) begin
          c.chain = END_MARK;
        end else if (k < 9) begin
          blk     = find_entry(END_MARK);
          c.chain = (blk >= 0) ? ENT_W'(blk) : END_MARK;
        end
      end else if (roll < 67) begin
        c.op = OP_LOOKUP;
        head = pick_head(len);
        if (head >= 0 && $urandom_range(0, 9) != 0) begin
          c.chain = ENT_W'(head);
          c.links = BLK_W'($urandom_range(0, len));
        end
      end else if (roll < 92) begin
        c.op = OP_REMOVE;
        head = pick_head(len);
        if (head >= 0 && $urandom_range(0, 9) != 0) begin
          c.chain = ENT_W'(head);
          k = (len > 1 && $urandom_range(0, 5) != 0) ? $urandom_range(1, len - 1)
                                                     : $urandom_range(0, len);
          pick = head;
          repeat (k) if (shadow_fat[pick] > 0) pick = int'(shadow_fat[pick]);
          c.tgt = BLK_W'(pick);
        end
      end
      send_request(c, 1'b0, '0);
      pace_sender();
    end

    cmd_if.valid <= 1'b0;
    drain_cnt = 0;
    while (pending_rsp_q.size() != 0 && drain_cnt < 500_000) begin
      @(posedge clk);
      drain_cnt++;
    end
    repeat (64) @(posedge clk);
    if (mismatch_cnt == 0 && pending_rsp_q.size() == 0) begin
      $display("fat_chain_table_engine_tb: PASS");
    end else begin
      $display("fat_chain_table_engine_tb: FAIL");
    end
    $finish;
  end

endmodule

### fat_chain_table_engine.f
src/fct_pkg.sv
src/fct_cmd_if.sv
src/fct_rsp_if.sv
src/fct_dp.sv
src/fct_ctrl.sv
src/fat_chain_table_engine.sv
dv/fat_chain_table_engine_tb.sv
